### rtl/modexp_pkg.sv
// Package: item types and sequencer states for the modular exponentiation block.
`timescale 1ns / 1ps
`default_nettype none
package modexp_pkg;

    // Fixed field widths of the items.
    localparam int unsigned FIELD_W = 32;

    typedef struct packed {
        logic [FIELD_W-1:0] base_value;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
    } me_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] power_result;
        logic               zero_modulus_error;
    } me_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_GO,
        ST_RED_WAIT,
        ST_CHECK,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_SQR_GO,
        ST_SQR_WAIT,
        ST_DONE
    } me_state_t;

endpackage
`default_nettype wire

### rtl/modexp_mulmod.sv
// Iterative modular multiplier: one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none
module modexp_mulmod #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,
    input  wire logic [WIDTH-1:0] addend,
    input  wire logic [WIDTH-1:0] mplier,
    input  wire logic [WIDTH-1:0] modulus,
    output logic                  done,
    output logic [WIDTH-1:0]      product
);

    localparam int unsigned CW = $clog2(WIDTH);
    localparam int unsigned TW = WIDTH + 2;

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    count_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] acc_next;
    logic [WIDTH-1:0] addend_reg;
    logic [WIDTH-1:0] mplier_reg;
    logic [WIDTH-1:0] mod_reg;

    logic [TW-1:0] sum;
    logic [TW-1:0] m1;
    logic [TW-1:0] m2;
    logic [TW-1:0] sel;

    // acc <= (2*acc + bit*addend) mod m; sum stays below 3m
    always_comb
    begin
        m1  = {2'b00, mod_reg};
        m2  = {1'b0, mod_reg, 1'b0};
        sum = {1'b0, acc_reg, 1'b0}
            + (mplier_reg[WIDTH-1] ? {2'b00, addend_reg} : {TW{1'b0}});
        if (sum >= m2)
        begin
            sel = sum - m2;
        end
        else if (sum >= m1)
        begin
            sel = sum - m1;
        end
        else
        begin
            sel = sum;
        end
        acc_next = sel[WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CW'(WIDTH - 1);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CW'(1);
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            acc_reg    <= '0;
            addend_reg <= addend;
            mplier_reg <= mplier;
            mod_reg    <= modulus;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mplier_reg <= {mplier_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

### rtl/modular_exponentiation.sv
// Top level: right-to-left square-and-multiply modular exponentiation.
`timescale 1ns / 1ps
`default_nettype none
// An item (base, exponent, modulus) is taken when start is high and busy is low.
// Operands are cut or zero-extended to OPERAND_WIDTH bits. The base is first
// reduced modulo the modulus, then each exponent bit costs a multiply if set
// and a square, except that the top bit needs no square; the walk stops once
// no exponent bits remain. All arithmetic goes through one shared modular
// multiplier that handles one multiplier bit per clock. A zero exponent
// gives 1. A zero modulus gives its result in the cycle right after accept,
// with the error flag set and a zero result. busy stays high throughout, and
// the next item can be taken in the cycle after the result. The result is
// shown for exactly one cycle with done high and cannot be held off, so the
// receiver must take it on that cycle.
module modular_exponentiation #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire modexp_pkg::me_in_t operands,
    output logic                    busy,
    output logic                    done,
    output modexp_pkg::me_out_t     result
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned FW = modexp_pkg::FIELD_W;

    modexp_pkg::me_state_t state_reg;
    modexp_pkg::me_state_t state_next;

    logic [W-1:0] base_reg, base_next;
    logic [W-1:0] exp_reg,  exp_next;
    logic [W-1:0] mod_reg,  mod_next;
    logic [W-1:0] r_reg,    r_next;
    logic         err_reg,  err_next;

    logic [W-1:0] in_base;
    logic [W-1:0] in_exp;
    logic [W-1:0] in_mod;
    logic [FW-1:0] r_out;

    logic         accept;
    logic         mm_go;
    logic [W-1:0] mm_addend;
    logic [W-1:0] mm_mplier;
    logic         mm_done;
    logic [W-1:0] mm_product;

    // Bring the 32-bit fields to operand width and back
    if (W > FW)
    begin : g_wide
        assign in_base = {{(W-FW){1'b0}}, operands.base_value};
        assign in_exp  = {{(W-FW){1'b0}}, operands.exponent};
        assign in_mod  = {{(W-FW){1'b0}}, operands.modulus};
    end
    else
    begin : g_narrow
        assign in_base = operands.base_value[W-1:0];
        assign in_exp  = operands.exponent[W-1:0];
        assign in_mod  = operands.modulus[W-1:0];
    end

    if (W >= FW)
    begin : g_out_wide
        assign r_out = r_reg[FW-1:0];
    end
    else
    begin : g_out_narrow
        assign r_out = {{(FW-W){1'b0}}, r_reg};
    end

    assign accept = start && !busy;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (in_mod == '0) ? modexp_pkg::ST_DONE
                                                : modexp_pkg::ST_RED_GO;
                end
            end
            modexp_pkg::ST_RED_GO:   state_next = modexp_pkg::ST_RED_WAIT;
            modexp_pkg::ST_RED_WAIT:
            begin
                if (mm_done)
                begin
                    state_next = modexp_pkg::ST_CHECK;
                end
            end
            modexp_pkg::ST_CHECK:
            begin
                if (exp_reg == '0)
                begin
                    state_next = modexp_pkg::ST_DONE;
                end
                else if (exp_reg[0])
                begin
                    state_next = modexp_pkg::ST_MUL_GO;
                end
                else
                begin
                    state_next = modexp_pkg::ST_SQR_GO;
                end
            end
            modexp_pkg::ST_MUL_GO:   state_next = modexp_pkg::ST_MUL_WAIT;
            modexp_pkg::ST_MUL_WAIT:
            begin
                if (mm_done)
                begin
                    // last exponent bit: the square would never be used
                    state_next = (exp_reg[W-1:1] == '0) ? modexp_pkg::ST_DONE
                                                        : modexp_pkg::ST_SQR_GO;
                end
            end
            modexp_pkg::ST_SQR_GO:   state_next = modexp_pkg::ST_SQR_WAIT;
            modexp_pkg::ST_SQR_WAIT:
            begin
                if (mm_done)
                begin
                    state_next = modexp_pkg::ST_CHECK;
                end
            end
            modexp_pkg::ST_DONE:     state_next = modexp_pkg::ST_IDLE;
            default:                 state_next = modexp_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake and multiplier operands
    always_comb
    begin
        busy      = 1'b1;
        done      = 1'b0;
        mm_go     = 1'b0;
        mm_addend = base_reg;
        mm_mplier = base_reg;
        case (state_reg)
            modexp_pkg::ST_IDLE:   busy = 1'b0;
            modexp_pkg::ST_RED_GO:
            begin
                // base mod m as 1 * base mod m
                mm_go     = 1'b1;
                mm_addend = W'(1);
            end
            modexp_pkg::ST_MUL_GO:
            begin
                mm_go     = 1'b1;
                mm_addend = r_reg;
            end
            modexp_pkg::ST_SQR_GO: mm_go = 1'b1;
            modexp_pkg::ST_DONE:   done  = 1'b1;
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        base_next = base_reg;
        exp_next  = exp_reg;
        mod_next  = mod_reg;
        r_next    = r_reg;
        err_next  = err_reg;
        case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    base_next = in_base;
                    exp_next  = in_exp;
                    mod_next  = in_mod;
                    err_next  = (in_mod == '0);
                    r_next    = (in_mod == '0) ? W'(0) : W'(1);
                end
            end
            modexp_pkg::ST_RED_WAIT:
            begin
                if (mm_done)
                begin
                    base_next = mm_product;
                end
            end
            modexp_pkg::ST_MUL_WAIT:
            begin
                if (mm_done)
                begin
                    r_next = mm_product;
                end
            end
            modexp_pkg::ST_SQR_WAIT:
            begin
                if (mm_done)
                begin
                    base_next = mm_product;
                    exp_next  = {1'b0, exp_reg[W-1:1]};
                end
            end
            default:
            begin
                r_next = r_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= modexp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        mod_reg  <= mod_next;
        r_reg    <= r_next;
        err_reg  <= err_next;
    end

    modexp_mulmod #(
        .WIDTH (W)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mm_go),
        .addend  (mm_addend),
        .mplier  (mm_mplier),
        .modulus (mod_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    assign result.power_result       = r_out;
    assign result.zero_modulus_error = err_reg;

endmodule
`default_nettype wire

### rtl/modexp_checker.sv
// Port-level checker for the modular exponentiation block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module modexp_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire modexp_pkg::me_out_t result
);

    // an accepted item keeps the block busy on the following cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an item was accepted");

    // a result only appears while the item is still held
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done raised while idle");

    // one result per item: the done strobe is never held high
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // block is free to take the next item right after the result
    a_free_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy still high after the result");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.zero_modulus_error) |-> (result.power_result == '0))
        else $error("non-zero result with the zero-modulus flag");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire
